>>> design/fpd_pkg.sv
// Package for the FM phase discriminator: CORDIC arctangent table,
// angle constants and the sequencer state type. No dependencies.
package fpd_pkg;

  localparam int unsigned TABLE_LEN          = 24;
  localparam int unsigned DEF_CORDIC_STAGES  = 16;
  localparam int unsigned SAMPLE_W           = 16;
  localparam int unsigned ANGLE_W            = 32;
  localparam int unsigned PHASE_W            = 16;
  // Guard bits: the sample scaled by 2^16 plus CORDIC gain stays below 2^34.
  localparam int unsigned XY_W               = 36;

  localparam logic [ANGLE_W-1:0] ANGLE_PI    = 32'h8000_0000;
  localparam logic [ANGLE_W-1:0] ANGLE_ROUND = 32'h0000_8000;

  // atan(2^-k) as a 32-bit binary angle, pi = 2^31
  localparam logic [ANGLE_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ITER = 3'b010,
    ST_DONE = 3'b100
  } fpd_state_e;

endpackage

>>> design/fm_phase_discriminator.sv
// FM phase discriminator top level: iterative vectoring CORDIC and phase differencing.
// Depends on fpd_pkg.
//
// Each request carries one complex sample (I, Q) and yields one result with the
// sample's phase (binary angle, 32768 = pi) and its difference from the previous
// sample's phase, which wraps naturally modulo 2^16. The phase comes from one
// shared add/subtract/shift CORDIC unit that runs one micro-rotation per cycle,
// so a sample goes through a load step, CORDIC_STAGES iterations (capped at the
// 24-entry table) and a write of the result register. A zero sample skips the
// iterations. The input is not ready while a sample is in work; a finished result
// waits in the output register and does not hold back the next request, unless
// the next result is ready before the previous one is taken.
module fm_phase_discriminator
  import fpd_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = DEF_CORDIC_STAGES  // 8 .. 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] i_sample, [31:16] q_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [15:0] freq_out, [31:16] phase_out
);

  localparam int unsigned CntW = $clog2(TABLE_LEN);
  // stage counts above the table length run the full table
  localparam int unsigned RunStages =
      (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam logic [CntW-1:0] LastStage = CntW'(RunStages - 1);

  fpd_state_e state_q, state_d;
  logic [CntW-1:0]           stage_q, stage_d;
  logic signed [XY_W-1:0]    x_q, x_d, y_q, y_d;
  logic [ANGLE_W-1:0]        z_q, z_d;
  logic [PHASE_W-1:0]        last_phase_q, last_phase_d;
  logic                      out_valid_q, out_valid_d;
  logic [PHASE_W-1:0]        freq_q, freq_d, phase_q, phase_d;

  logic signed [SAMPLE_W-1:0] i_smp, q_smp;
  logic signed [XY_W-1:0]     x_init, y_init, x_shr, y_shr;
  logic [ANGLE_W-1:0]         z_round;
  logic [PHASE_W-1:0]         phase_new;
  logic                       in_req, out_free;

  assign i_smp = s_axis_tdata[15:0];
  assign q_smp = s_axis_tdata[31:16];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {phase_q, freq_q};

  // sample scaled by 2^16, sign-extended into the guard bits
  assign x_init = {{(XY_W-SAMPLE_W-16){i_smp[SAMPLE_W-1]}}, i_smp, 16'h0000};
  assign y_init = {{(XY_W-SAMPLE_W-16){q_smp[SAMPLE_W-1]}}, q_smp, 16'h0000};

  // shared micro-rotation datapath: arithmetic shifts floor
  assign x_shr = x_q >>> stage_q;
  assign y_shr = y_q >>> stage_q;

  assign z_round   = z_q + ANGLE_ROUND;
  assign phase_new = z_round[ANGLE_W-1:ANGLE_W-PHASE_W];

  always_comb begin
    state_d      = state_q;
    stage_d      = stage_q;
    x_d          = x_q;
    y_d          = y_q;
    z_d          = z_q;
    last_phase_d = last_phase_q;
    out_valid_d  = out_valid_q;
    freq_d       = freq_q;
    phase_d      = phase_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_req) begin
          stage_d = '0;
          if (i_smp == '0 && q_smp == '0) begin
            z_d     = '0;
            state_d = ST_DONE;
          end else if (i_smp[SAMPLE_W-1]) begin
            // left half plane: turn by pi first
            x_d     = -x_init;
            y_d     = -y_init;
            z_d     = ANGLE_PI;
            state_d = ST_ITER;
          end else begin
            x_d     = x_init;
            y_d     = y_init;
            z_d     = '0;
            state_d = ST_ITER;
          end
        end
      end
      ST_ITER: begin
        if (!y_q[XY_W-1]) begin
          x_d = x_q + y_shr;
          y_d = y_q - x_shr;
          z_d = z_q + ATAN_TAB[stage_q];
        end else begin
          x_d = x_q - y_shr;
          y_d = y_q + x_shr;
          z_d = z_q - ATAN_TAB[stage_q];
        end
        stage_d = stage_q + 1'b1;
        if (stage_q == LastStage) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register can take the result
        if (out_free) begin
          phase_d      = phase_new;
          freq_d       = phase_new - last_phase_q;
          last_phase_d = phase_new;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      stage_q      <= '0;
      last_phase_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      stage_q      <= stage_d;
      last_phase_q <= last_phase_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    freq_q  <= freq_d;
    phase_q <= phase_d;
  end

endmodule

>>> test/fm_phase_discriminator_tb.sv
// Self-checking testbench for fm_phase_discriminator: directed and random I/Q samples
// go in over the request stream; phase and phase difference are checked per result.
// Depends only on the fm_phase_discriminator RTL (and fpd_pkg through it).
module fm_phase_discriminator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STAGES      = 16;
  localparam int unsigned N_DIRECTED  = 21;
  localparam int unsigned N_RANDOM    = 1750;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 2 * STAGES + 8;
  localparam longint     LIMIT_CYCLES = 1_000_000;

  localparam logic [31:0] ANGLE_HALF_TURN = 32'h8000_0000;
  localparam logic [31:0] ANGLE_ROUNDING  = 32'h0000_8000;

  // atan(2^-k) as 32-bit binary angle, pi = 2^31
  localparam logic [31:0] ARCTAN_STEPS [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  localparam logic [15:0] EDGE_VALUES [6] = '{
    16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF
  };

  typedef struct packed {
    logic [15:0] freq;
    logic [15:0] phase;
  } disc_result_t;

  typedef struct packed {
    logic [15:0] i_s;
    logic [15:0] q_s;
    bit          typed;
    logic [15:0] freq;
    logic [15:0] phase;
  } stim_row_t;

  // Typed rows (zero vectors) carry their own result; the rest go through the predictor.
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000},
    '{16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000},
    '{16'h7FFF, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{16'h8000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{16'h0000, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    '{16'h0000, 16'h8000, 1'b0, 16'h0000, 16'h0000},
    '{16'hFFFF, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{16'h0001, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000},
    '{16'h7FFF, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    '{16'h8000, 16'h8000, 1'b0, 16'h0000, 16'h0000},
    '{16'h8000, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    '{16'h7FFF, 16'h8000, 1'b0, 16'h0000, 16'h0000},
    '{16'hFFFF, 16'hFFFF, 1'b0, 16'h0000, 16'h0000},
    '{16'hFFFF, 16'h0001, 1'b0, 16'h0000, 16'h0000},
    '{16'h0001, 16'hFFFF, 1'b0, 16'h0000, 16'h0000},
    '{16'h8000, 16'h0001, 1'b0, 16'h0000, 16'h0000},
    '{16'h8000, 16'hFFFF, 1'b0, 16'h0000, 16'h0000},
    '{16'h5555, 16'hAAAA, 1'b0, 16'h0000, 16'h0000},
    '{16'hAAAA, 16'h5555, 1'b0, 16'h0000, 16'h0000}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  disc_result_t pending_results[$];
  logic [15:0]  prev_phase     = '0;
  int unsigned  mismatch_count = 0;
  longint       cycle_count    = 0;
  int unsigned  idle_pct       = 0;
  int unsigned  stall_pct      = 0;
  bit           hold_req       = 1'b0;

  fm_phase_discriminator #(
    .CORDIC_STAGES(STAGES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [15:0] i_sample, [31:16] q_sample
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)    // [15:0] freq_out, [31:16] phase_out
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("fm_phase_discriminator_tb: done, errors");
      $finish;
    end
  end

  // Vectoring CORDIC on the sample, then difference against the stored phase.
  function automatic disc_result_t discriminate(logic [15:0] i_s, logic [15:0] q_s);
    longint       x;
    longint       y;
    longint       xs;
    longint       ys;
    logic [31:0]  z;
    logic [31:0]  z_rounded;
    disc_result_t res;
    z = '0;
    if (i_s == '0 && q_s == '0) begin
      res.phase = '0;
    end else begin
      x = longint'($signed(i_s)) * 65536;
      y = longint'($signed(q_s)) * 65536;
      // left half plane: turn by pi first
      if (x < 0) begin
        x = -x;
        y = -y;
        z = ANGLE_HALF_TURN;
      end
      for (int k = 0; k < STAGES && k < 24; k++) begin
        xs = x >>> k;
        ys = y >>> k;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ARCTAN_STEPS[k];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ARCTAN_STEPS[k];
        end
      end
      z_rounded = z + ANGLE_ROUNDING;
      res.phase = z_rounded[31:16];
    end
    res.freq   = res.phase - prev_phase;
    prev_phase = res.phase;
    return res;
  endfunction

  task automatic send_sample(input logic [15:0] i_s, input logic [15:0] q_s,
                             input bit typed, input logic [15:0] t_freq,
                             input logic [15:0] t_phase);
    disc_result_t predicted;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {q_s, i_s};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = discriminate(i_s, q_s);
    if (typed) begin
      predicted.freq  = t_freq;
      predicted.phase = t_phase;
    end
    pending_results.push_back(predicted);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    disc_result_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no pending request: tdata %h", m_axis_tdata);
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (m_axis_tdata[15:0] !== exp_res.freq) begin
          $error("freq_out: expected %0d, actual %0d",
                 $signed(exp_res.freq), $signed(m_axis_tdata[15:0]));
          mismatch_count++;
        end
        if (m_axis_tdata[31:16] !== exp_res.phase) begin
          $error("phase_out: expected %0d, actual %0d",
                 $signed(exp_res.phase), $signed(m_axis_tdata[31:16]));
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic [15:0] i_s;
    logic [15:0] q_s;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    idle_pct  = 20;
    stall_pct = 10;
    for (int r = 0; r < N_DIRECTED; r++) begin
      send_sample(DIRECTED_ROWS[r].i_s, DIRECTED_ROWS[r].q_s, DIRECTED_ROWS[r].typed,
                  DIRECTED_ROWS[r].freq, DIRECTED_ROWS[r].phase);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      // vary the pressure: busy, quiet, heavy, then a clean tail
      if (n == 0) begin
        idle_pct  = 30;
        stall_pct = 10;
      end else if (n == 600) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else if (n == 1000) begin
        idle_pct  = 50;
        stall_pct = 25;
      end else if (n == N_RANDOM - 250) begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      if (n == 300) begin
        hold_req = 1'b1;
      end
      case ($urandom_range(0, 9))
        0: begin
          i_s = '0;
          q_s = '0;
        end
        1: begin
          i_s = 16'($urandom_range(0, 8)) - 16'd4;
          q_s = 16'($urandom_range(0, 8)) - 16'd4;
        end
        2: begin
          i_s = EDGE_VALUES[$urandom_range(0, 5)];
          q_s = EDGE_VALUES[$urandom_range(0, 5)];
        end
        3: begin
          // land on an axis
          if ($urandom_range(0, 1) == 0) begin
            i_s = '0;
            q_s = 16'($urandom);
          end else begin
            i_s = 16'($urandom);
            q_s = '0;
          end
        end
        default: begin
          i_s = 16'($urandom);
          q_s = 16'($urandom);
        end
      endcase
      send_sample(i_s, q_s, 1'b0, '0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("fm_phase_discriminator_tb: done, clean");
    end else begin
      $display("fm_phase_discriminator_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
design/fpd_pkg.sv
design/fm_phase_discriminator.sv
test/fm_phase_discriminator_tb.sv
